// ===== hw/rtl/bfr_pkg.sv =====
// ----------------------------------------------------------------------------
// bfr_pkg
// Shared types, widths and constants of the bitmap font text renderer.
// ----------------------------------------------------------------------------
package bfr_pkg;

	// Default sizes of the block
	localparam int GLYPH_STORE_BYTES_DEF = 4096;
	localparam int GLYPH_ROWS_DEF        = 16;
	localparam int GLYPH_WIDTH           = 8;

	// Field widths
	localparam int KIND_W      = 2;
	localparam int CODE_W      = 8;
	localparam int GADDR_W     = 12;
	localparam int BYTE_W      = 8;
	localparam int COORD_W     = 12;
	localparam int OFFSET_W    = 25;
	localparam int COLOUR_W    = 32;
	localparam int PITCH_W     = 13;
	localparam int SWIDTH_W    = 13;
	localparam int STRIDE_W    = 5;
	localparam int BASE_W      = CODE_W + STRIDE_W;
	// Wide enough for a glyph row address and the largest store (16384 bytes)
	localparam int ADDR_SUM_W  = 14;
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 32;

	localparam logic [COORD_W-1:0] COORD_MAX = '1;

	// Register reset values
	localparam logic [COLOUR_W-1:0] DRAW_COLOUR_RST  = 32'h0FFF_FFFF;
	localparam logic [PITCH_W-1:0]  LINE_PITCH_RST   = 13'd1024;
	localparam logic [SWIDTH_W-1:0] SCREEN_WIDTH_RST = 13'd1024;
	localparam logic [STRIDE_W-1:0] GLYPH_STRIDE_RST = 5'd16;

	typedef enum logic [KIND_W-1:0] {
		KIND_DRAW   = 2'd0,
		KIND_LOAD   = 2'd1,
		KIND_CURSOR = 2'd2
	} kind_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DRAW_COLOUR  = 4'd0,
		REG_LINE_PITCH   = 4'd1,
		REG_SCREEN_WIDTH = 4'd2,
		REG_GLYPH_STRIDE = 4'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_OFFSET,
		ST_ROWS
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic take;        // input channel ready
		logic draw_start;  // form code*stride and y*pitch, clear row count
		logic load_we;     // write one glyph byte
		logic cursor_we;   // place the cursor
		logic acc_init;    // first row offset = x + y*pitch
		logic row_fire;    // read one glyph row into the output register
		logic advance;     // move the cursor after the last row
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic slot_free;   // output register empty or being taken
		logic row_last;    // row count is at the last glyph row
	} status_t;

endpackage

// ===== hw/rtl/bfr_item_if.sv =====
// ----------------------------------------------------------------------------
// bfr_item_if
// Input item channel: draw, glyph load and set-cursor items.
// ----------------------------------------------------------------------------
interface bfr_item_if;
	logic                           valid;
	logic                           ready;
	logic [bfr_pkg::KIND_W-1:0]     kind;
	logic [bfr_pkg::CODE_W-1:0]     char_code;
	logic [bfr_pkg::GADDR_W-1:0]    glyph_address;
	logic [bfr_pkg::BYTE_W-1:0]     glyph_byte;
	logic [bfr_pkg::COORD_W-1:0]    new_cursor_x;
	logic [bfr_pkg::COORD_W-1:0]    new_cursor_y;

	modport source (
		output valid, kind, char_code, glyph_address, glyph_byte, new_cursor_x, new_cursor_y,
		input  ready
	);
	modport sink (
		input  valid, kind, char_code, glyph_address, glyph_byte, new_cursor_x, new_cursor_y,
		output ready
	);
endinterface

// ===== hw/rtl/bfr_result_if.sv =====
// ----------------------------------------------------------------------------
// bfr_result_if
// Result channel: one framebuffer row write per transfer.
// ----------------------------------------------------------------------------
interface bfr_result_if;
	logic                           valid;
	logic                           ready;
	logic [bfr_pkg::OFFSET_W-1:0]   pixel_offset;
	logic [bfr_pkg::BYTE_W-1:0]     row_mask;
	logic [bfr_pkg::COLOUR_W-1:0]   pixel_colour;
	logic                           last_row;

	modport source (
		output valid, pixel_offset, row_mask, pixel_colour, last_row,
		input  ready
	);
	modport sink (
		input  valid, pixel_offset, row_mask, pixel_colour, last_row,
		output ready
	);
endinterface

// ===== hw/rtl/bfr_cfg_if.sv =====
// ----------------------------------------------------------------------------
// bfr_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bfr_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [bfr_pkg::CFG_INDEX_W-1:0]  index;
	logic [bfr_pkg::CFG_DATA_W-1:0]   data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

// ===== hw/rtl/bitmap_font_text_renderer_top.sv =====
// Bitmap font text renderer. Items arrive on the item channel: a glyph load
// writes one byte of the glyph RAM, a set-cursor item places the pixel cursor,
// both taken back to back. A draw item turns into GLYPH_ROWS
// results, one per glyph row, each carrying the framebuffer word offset
// x + (y + row) * line_pitch (low 25 bits), the row's 8-bit mask (bit 7 is the
// leftmost pixel), the draw colour and a flag on the last row. A draw goes
// through the accept state, which also forms code*stride and y*pitch in two
// multipliers, a state that forms the first row's offset, then one row per
// cycle through the single read port of the glyph RAM, while results are
// taken; a result not taken holds the row sequence. After the last
// row the cursor moves right by 8 pixels, or wraps to x = 0 and y + GLYPH_ROWS
// (saturating at 4095) when the next glyph would pass screen_width. The glyph
// RAM has no reset; rows never loaded read back as whatever the RAM holds.
// GLYPH_STORE_BYTES must be a power of two; glyph addresses wrap modulo it.
// Configuration writes are taken every cycle and must only come while the
// block is idle.
// ----------------------------------------------------------------------------
// bitmap_font_text_renderer_top
// Top level: item, result and configuration channels around the controller
// and the datapath.
// ----------------------------------------------------------------------------
module bitmap_font_text_renderer_top #(
	parameter int GLYPH_STORE_BYTES = bfr_pkg::GLYPH_STORE_BYTES_DEF,
	parameter int GLYPH_ROWS        = bfr_pkg::GLYPH_ROWS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	bfr_item_if.sink      item,
	bfr_result_if.source  result,
	bfr_cfg_if.sink       cfg
);

	bfr_pkg::cmd_t    cmd;
	bfr_pkg::status_t status;

	// Registers are plain flops: every write transfer is taken at once
	assign cfg.ready = 1'b1;

	// The input side is open whenever the sequencer is idle, even while
	// the last row of the previous character still waits for its transfer
	assign item.ready = cmd.take;

	bfr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_kind  (item.kind),
		.status     (status),
		.cmd        (cmd)
	);

	// Glyph RAM, cursor, registers and the output register that holds a
	// result until the sink takes it
	bfr_datapath #(
		.GLYPH_STORE_BYTES (GLYPH_STORE_BYTES),
		.GLYPH_ROWS        (GLYPH_ROWS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.char_code     (item.char_code),
		.glyph_address (item.glyph_address),
		.glyph_byte    (item.glyph_byte),
		.new_cursor_x  (item.new_cursor_x),
		.new_cursor_y  (item.new_cursor_y),
		.cfg_valid     (cfg.valid),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.out_ready     (result.ready),
		.out_valid     (result.valid),
		.pixel_offset  (result.pixel_offset),
		.row_mask      (result.row_mask),
		.pixel_colour  (result.pixel_colour),
		.last_row      (result.last_row)
	);

endmodule

// ===== hw/rtl/bfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfr_ctrl
// Controller: accepts items, sequences the offset setup and the glyph rows.
// ----------------------------------------------------------------------------
module bfr_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	input  logic [bfr_pkg::KIND_W-1:0]   item_kind,
	input  bfr_pkg::status_t             status,
	output bfr_pkg::cmd_t                cmd
);

	bfr_pkg::state_t state_q;
	bfr_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			bfr_pkg::ST_IDLE: begin
				cmd.take = 1'b1;
				if (item_valid) begin
					unique case (bfr_pkg::kind_t'(item_kind))
						bfr_pkg::KIND_DRAW: begin
							cmd.draw_start = 1'b1;
							state_d        = bfr_pkg::ST_OFFSET;
						end
						bfr_pkg::KIND_LOAD:   cmd.load_we   = 1'b1;
						bfr_pkg::KIND_CURSOR: cmd.cursor_we = 1'b1;
						default: ; // unused kind: drop
					endcase
				end
			end
			bfr_pkg::ST_OFFSET: begin
				cmd.acc_init = 1'b1;
				state_d      = bfr_pkg::ST_ROWS;
			end
			bfr_pkg::ST_ROWS: begin
				// advance one row only when the output register frees up
				if (status.slot_free) begin
					cmd.row_fire = 1'b1;
					if (status.row_last) begin
						cmd.advance = 1'b1;
						state_d     = bfr_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = bfr_pkg::ST_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/bfr_datapath.sv =====
// ----------------------------------------------------------------------------
// bfr_datapath
// Glyph RAM, cursor, configuration registers, offset accumulator and the
// output register.
// ----------------------------------------------------------------------------
module bfr_datapath #(
	parameter int GLYPH_STORE_BYTES = bfr_pkg::GLYPH_STORE_BYTES_DEF,
	parameter int GLYPH_ROWS        = bfr_pkg::GLYPH_ROWS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bfr_pkg::cmd_t                    cmd,
	output bfr_pkg::status_t                 status,
	input  logic [bfr_pkg::CODE_W-1:0]       char_code,
	input  logic [bfr_pkg::GADDR_W-1:0]      glyph_address,
	input  logic [bfr_pkg::BYTE_W-1:0]       glyph_byte,
	input  logic [bfr_pkg::COORD_W-1:0]      new_cursor_x,
	input  logic [bfr_pkg::COORD_W-1:0]      new_cursor_y,
	input  logic                             cfg_valid,
	input  logic [bfr_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [bfr_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic [bfr_pkg::OFFSET_W-1:0]     pixel_offset,
	output logic [bfr_pkg::BYTE_W-1:0]       row_mask,
	output logic [bfr_pkg::COLOUR_W-1:0]     pixel_colour,
	output logic                             last_row
);

	localparam int ADDR_W = $clog2(GLYPH_STORE_BYTES);
	localparam int ROW_W  = $clog2(GLYPH_ROWS);
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GLYPH_ROWS - 1);
	localparam logic [bfr_pkg::COORD_W:0] ROW_STEP = (bfr_pkg::COORD_W + 1)'(GLYPH_ROWS);
	localparam logic [bfr_pkg::COORD_W:0] COL_STEP =
		(bfr_pkg::COORD_W + 1)'(bfr_pkg::GLYPH_WIDTH);

	// Configuration registers
	logic [bfr_pkg::COLOUR_W-1:0] draw_colour_q;
	logic [bfr_pkg::PITCH_W-1:0]  line_pitch_q;
	logic [bfr_pkg::SWIDTH_W-1:0] screen_width_q;
	logic [bfr_pkg::STRIDE_W-1:0] glyph_stride_q;

	// Cursor
	logic [bfr_pkg::COORD_W-1:0]  cursor_x_q;
	logic [bfr_pkg::COORD_W-1:0]  cursor_y_q;

	// Per-character working registers
	logic [bfr_pkg::BASE_W-1:0]   base_q;
	logic [bfr_pkg::OFFSET_W-1:0] ypitch_q;
	logic [bfr_pkg::OFFSET_W-1:0] acc_q;
	logic [ROW_W-1:0]             row_q;

	// Output register
	logic                         out_valid_q;
	logic [bfr_pkg::OFFSET_W-1:0] offset_q;
	logic [bfr_pkg::BYTE_W-1:0]   mask_q;
	logic                         last_q;

	logic [bfr_pkg::BYTE_W-1:0]   glyph_mem [GLYPH_STORE_BYTES];

	logic [bfr_pkg::ADDR_SUM_W-1:0] rd_full;
	logic [bfr_pkg::ADDR_SUM_W-1:0] wr_full;
	logic [ADDR_W-1:0]              rd_addr;
	logic [ADDR_W-1:0]              wr_addr;
	logic [bfr_pkg::COORD_W:0]      next_x;
	logic [bfr_pkg::COORD_W:0]      next_y;
	logic                           wrap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_colour_q  <= bfr_pkg::DRAW_COLOUR_RST;
			line_pitch_q   <= bfr_pkg::LINE_PITCH_RST;
			screen_width_q <= bfr_pkg::SCREEN_WIDTH_RST;
			glyph_stride_q <= bfr_pkg::GLYPH_STRIDE_RST;
		end else if (cfg_valid) begin
			unique case (bfr_pkg::cfg_reg_t'(cfg_index))
				bfr_pkg::REG_DRAW_COLOUR:  draw_colour_q  <= cfg_data;
				bfr_pkg::REG_LINE_PITCH:   line_pitch_q   <= cfg_data[bfr_pkg::PITCH_W-1:0];
				bfr_pkg::REG_SCREEN_WIDTH: screen_width_q <= cfg_data[bfr_pkg::SWIDTH_W-1:0];
				bfr_pkg::REG_GLYPH_STRIDE: glyph_stride_q <= cfg_data[bfr_pkg::STRIDE_W-1:0];
				default: ;
			endcase
		end
	end

	// Cursor advance and line wrap
	always_comb begin
		next_x = {1'b0, cursor_x_q} + COL_STEP;
		next_y = {1'b0, cursor_y_q} + ROW_STEP;
		wrap   = next_x[bfr_pkg::COORD_W] || ((next_x + COL_STEP) > screen_width_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= '0;
			cursor_y_q <= '0;
		end else if (cmd.cursor_we) begin
			cursor_x_q <= new_cursor_x;
			cursor_y_q <= new_cursor_y;
		end else if (cmd.advance) begin
			if (wrap) begin
				cursor_x_q <= '0;
				cursor_y_q <= next_y[bfr_pkg::COORD_W] ? bfr_pkg::COORD_MAX
					: next_y[bfr_pkg::COORD_W-1:0];
			end else begin
				cursor_x_q <= next_x[bfr_pkg::COORD_W-1:0];
			end
		end
	end

	// Setup products, then one pitch step per row
	always_ff @(posedge clk) begin
		if (cmd.draw_start) begin
			base_q   <= {{bfr_pkg::STRIDE_W{1'b0}}, char_code}
				* {{bfr_pkg::CODE_W{1'b0}}, glyph_stride_q};
			ypitch_q <= {{bfr_pkg::PITCH_W{1'b0}}, cursor_y_q}
				* {{bfr_pkg::COORD_W{1'b0}}, line_pitch_q};
		end
		if (cmd.acc_init) begin
			acc_q <= bfr_pkg::OFFSET_W'(cursor_x_q) + ypitch_q;
		end else if (cmd.row_fire) begin
			acc_q <= acc_q + bfr_pkg::OFFSET_W'(line_pitch_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (cmd.draw_start) begin
			row_q <= '0;
		end else if (cmd.row_fire) begin
			row_q <= row_q + 1'b1;
		end
	end

	// Store addresses wrap modulo the store size
	assign rd_full = bfr_pkg::ADDR_SUM_W'(base_q) + bfr_pkg::ADDR_SUM_W'(row_q);
	assign wr_full = bfr_pkg::ADDR_SUM_W'(glyph_address);
	assign rd_addr = rd_full[ADDR_W-1:0];
	assign wr_addr = wr_full[ADDR_W-1:0];

	// Glyph RAM: one write port, one registered read port feeding row_mask
	always_ff @(posedge clk) begin
		if (cmd.load_we) begin
			glyph_mem[wr_addr] <= glyph_byte;
		end
		if (cmd.row_fire) begin
			mask_q <= glyph_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.row_fire) begin
			offset_q <= acc_q;
			last_q   <= (row_q == LAST_ROW);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.row_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.slot_free = !out_valid_q || out_ready;
	assign status.row_last  = (row_q == LAST_ROW);

	assign out_valid    = out_valid_q;
	assign pixel_offset = offset_q;
	assign row_mask     = mask_q;
	assign pixel_colour = draw_colour_q;
	assign last_row     = last_q;

endmodule

// ===== tb/sv/bitmap_font_text_renderer_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_font_text_renderer_top_tb
// Self-checking bench for the text renderer. A queue of items feeds a clocked
// driver; a clocked receiver takes row writes and compares each one with the
// rows that a cycle-free copy of the renderer predicted when the item was
// accepted. The run goes through several register settings, with random gaps
// on both channels.
// ----------------------------------------------------------------------------
module bitmap_font_text_renderer_top_tb;

	localparam int STORE_BYTES  = bfr_pkg::GLYPH_STORE_BYTES_DEF;
	localparam int ROWS         = bfr_pkg::GLYPH_ROWS_DEF;
	// Margin left when idle, past the end of the last draw
	localparam int DRAIN_CYCLES = 24;

	// Unused item kind: the block must drop it without a trace
	localparam logic [bfr_pkg::KIND_W-1:0] KIND_NONE = 2'd3;

	typedef struct {
		logic [bfr_pkg::KIND_W-1:0]  kind;
		logic [bfr_pkg::CODE_W-1:0]  char_code;
		logic [bfr_pkg::GADDR_W-1:0] glyph_address;
		logic [bfr_pkg::BYTE_W-1:0]  glyph_byte;
		logic [bfr_pkg::COORD_W-1:0] new_cursor_x;
		logic [bfr_pkg::COORD_W-1:0] new_cursor_y;
	} text_item_t;

	typedef struct {
		logic [bfr_pkg::OFFSET_W-1:0] offset;
		logic [bfr_pkg::BYTE_W-1:0]   mask;
		logic [bfr_pkg::COLOUR_W-1:0] colour;
		logic                         last;
	} row_write_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	bfr_item_if   item_ch ();
	bfr_result_if row_ch ();
	bfr_cfg_if    cfg_ch ();

	bitmap_font_text_renderer_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (row_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Renderer copy: register shadows, cursor and glyph bytes
	// ------------------------------------------------------------------------
	logic [bfr_pkg::COLOUR_W-1:0] colour_reg = bfr_pkg::DRAW_COLOUR_RST;
	logic [bfr_pkg::PITCH_W-1:0]  pitch_reg  = bfr_pkg::LINE_PITCH_RST;
	logic [bfr_pkg::SWIDTH_W-1:0] width_reg  = bfr_pkg::SCREEN_WIDTH_RST;
	logic [bfr_pkg::STRIDE_W-1:0] stride_reg = bfr_pkg::GLYPH_STRIDE_RST;
	logic [bfr_pkg::COORD_W-1:0]  cursor_col = '0;
	logic [bfr_pkg::COORD_W-1:0]  cursor_row = '0;
	logic [bfr_pkg::BYTE_W-1:0]   glyph_copy [STORE_BYTES];

	// Stimulus side: glyph bytes already loaded, so a draw never reads junk
	bit glyph_loaded [STORE_BYTES];

	text_item_t pending_items [$];
	row_write_t expected_rows [$];
	text_item_t held_item;

	int items_queued   = 0;
	int items_accepted = 0;
	int counted_items  = 0;
	int failures       = 0;

	// Apply one accepted item to the copy and queue the rows it must produce.
	function automatic void render_item(input text_item_t it);
		int unsigned     base;
		int unsigned     next_x;
		int unsigned     next_y;
		longint unsigned off;
		row_write_t      w;
		case (it.kind)
			bfr_pkg::KIND_LOAD: begin
				glyph_copy[it.glyph_address] = it.glyph_byte;
			end
			bfr_pkg::KIND_CURSOR: begin
				cursor_col = it.new_cursor_x;
				cursor_row = it.new_cursor_y;
			end
			bfr_pkg::KIND_DRAW: begin
				base = it.char_code * stride_reg;
				for (int row = 0; row < ROWS; row++) begin
					off = longint'(cursor_col)
						+ longint'(cursor_row + row) * longint'(pitch_reg);
					w.offset = off[bfr_pkg::OFFSET_W-1:0];
					w.mask   = glyph_copy[(base + row) % STORE_BYTES];
					w.colour = colour_reg;
					w.last   = (row == ROWS - 1);
					expected_rows.push_back(w);
				end
				// Advance the cursor; wrap when the next glyph would not fit
				next_x = cursor_col + bfr_pkg::GLYPH_WIDTH;
				if (next_x > bfr_pkg::COORD_MAX
					|| next_x + bfr_pkg::GLYPH_WIDTH > width_reg) begin
					next_y     = cursor_row + ROWS;
					cursor_col = '0;
					cursor_row = (next_y > bfr_pkg::COORD_MAX) ? bfr_pkg::COORD_MAX
						: next_y[bfr_pkg::COORD_W-1:0];
				end else begin
					cursor_col = next_x[bfr_pkg::COORD_W-1:0];
				end
			end
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Gap picker shared by both sides: mostly none or short, a few long
	// ------------------------------------------------------------------------
	function automatic int pick_gap(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// ------------------------------------------------------------------------
	// Driver: present queued items, hold each until its transfer
	// ------------------------------------------------------------------------
	int send_gap;
	bit send_calm;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid         <= 1'b0;
			item_ch.kind          <= bfr_pkg::KIND_DRAW;
			item_ch.char_code     <= '0;
			item_ch.glyph_address <= '0;
			item_ch.glyph_byte    <= '0;
			item_ch.new_cursor_x  <= '0;
			item_ch.new_cursor_y  <= '0;
			send_gap  = 0;
			send_calm = 1'b0;
		end else begin
			// Predict at the transfer, with the registers as they stand now
			if (item_ch.valid && item_ch.ready) begin
				render_item(held_item);
				items_accepted++;
			end
			// Flip into or out of a stretch with no gaps now and then
			if ($urandom_range(0, 49) == 0)
				send_calm = !send_calm;
			if (!item_ch.valid || item_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					item_ch.valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					held_item = pending_items.pop_front();
					item_ch.kind          <= held_item.kind;
					item_ch.char_code     <= held_item.char_code;
					item_ch.glyph_address <= held_item.glyph_address;
					item_ch.glyph_byte    <= held_item.glyph_byte;
					item_ch.new_cursor_x  <= held_item.new_cursor_x;
					item_ch.new_cursor_y  <= held_item.new_cursor_y;
					item_ch.valid         <= 1'b1;
					send_gap = pick_gap(send_calm);
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: stall at random, check every row write against the oldest
	// prediction
	// ------------------------------------------------------------------------
	int take_gap;
	bit take_calm;

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			failures++;
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		row_write_t want;
		if (!arst_n) begin
			row_ch.ready <= 1'b0;
			take_gap  = 0;
			take_calm = 1'b0;
		end else begin
			if (row_ch.valid && row_ch.ready) begin
				if (expected_rows.size() == 0) begin
					failures++;
					$display("%0t: row write with none expected, offset %0h mask %0h",
						$time, row_ch.pixel_offset, row_ch.row_mask);
				end else begin
					want = expected_rows.pop_front();
					check_field("pixel_offset", want.offset, row_ch.pixel_offset);
					check_field("row_mask", want.mask, row_ch.row_mask);
					check_field("pixel_colour", want.colour, row_ch.pixel_colour);
					check_field("last_row", want.last, row_ch.last_row);
				end
			end
			if ($urandom_range(0, 49) == 0)
				take_calm = !take_calm;
			if (take_gap > 0) begin
				take_gap--;
				row_ch.ready <= 1'b0;
			end else begin
				row_ch.ready <= 1'b1;
				take_gap = pick_gap(take_calm);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Item builders
	// ------------------------------------------------------------------------
	// Fill every field with noise; the block must ignore fields its kind
	// does not use
	function automatic text_item_t random_item(input logic [bfr_pkg::KIND_W-1:0] k);
		text_item_t it;
		it.kind          = k;
		it.char_code     = bfr_pkg::CODE_W'($urandom_range(0, 255));
		it.glyph_address = bfr_pkg::GADDR_W'($urandom_range(0, 4095));
		it.glyph_byte    = bfr_pkg::BYTE_W'($urandom_range(0, 255));
		it.new_cursor_x  = bfr_pkg::COORD_W'($urandom_range(0, 4095));
		it.new_cursor_y  = bfr_pkg::COORD_W'($urandom_range(0, 4095));
		return it;
	endfunction

	function automatic void queue_item(input text_item_t it);
		pending_items.push_back(it);
		items_queued++;
		if (it.kind != KIND_NONE)
			counted_items++;
	endfunction

	function automatic void load_byte(input logic [bfr_pkg::GADDR_W-1:0] addr,
		input logic [bfr_pkg::BYTE_W-1:0] bits);
		text_item_t it;
		it = random_item(bfr_pkg::KIND_LOAD);
		it.glyph_address   = addr;
		it.glyph_byte      = bits;
		glyph_loaded[addr] = 1'b1;
		queue_item(it);
	endfunction

	function automatic void place_cursor(input logic [bfr_pkg::COORD_W-1:0] x,
		input logic [bfr_pkg::COORD_W-1:0] y);
		text_item_t it;
		it = random_item(bfr_pkg::KIND_CURSOR);
		it.new_cursor_x = x;
		it.new_cursor_y = y;
		queue_item(it);
	endfunction

	// Load whatever rows of the glyph are still blank, then draw it
	function automatic void draw_char(input logic [bfr_pkg::CODE_W-1:0] code);
		text_item_t  it;
		int unsigned a;
		for (int row = 0; row < ROWS; row++) begin
			a = (code * stride_reg + row) % STORE_BYTES;
			if (!glyph_loaded[a])
				load_byte(a[bfr_pkg::GADDR_W-1:0],
					bfr_pkg::BYTE_W'($urandom_range(0, 255)));
		end
		it = random_item(bfr_pkg::KIND_DRAW);
		it.char_code = code;
		queue_item(it);
	endfunction

	// ------------------------------------------------------------------------
	// Random traffic: mostly draws of a small set of glyphs (so the loads pay
	// off), glyph rewrites, cursor moves near the edges, and a few stray items
	// ------------------------------------------------------------------------
	function automatic void random_burst(input int n);
		logic [bfr_pkg::CODE_W-1:0]  pool [6];
		logic [bfr_pkg::COORD_W-1:0] x;
		logic [bfr_pkg::COORD_W-1:0] y;
		int                          start;
		int                          r;
		int unsigned                 lim;
		text_item_t                  it;
		foreach (pool[i])
			pool[i] = bfr_pkg::CODE_W'($urandom_range(0, 255));
		start = counted_items;
		while (counted_items - start < n) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				if ($urandom_range(0, 99) < 80)
					draw_char(pool[$urandom_range(0, 5)]);
				else
					draw_char(bfr_pkg::CODE_W'($urandom_range(0, 255)));
			end else if (r < 75) begin
				// Rewrite a row of a pooled glyph, or any byte of the store
				if ($urandom_range(0, 1))
					load_byte(bfr_pkg::GADDR_W'((pool[$urandom_range(0, 5)] * stride_reg
						+ $urandom_range(0, ROWS - 1)) % STORE_BYTES),
						bfr_pkg::BYTE_W'($urandom_range(0, 255)));
				else
					load_byte(bfr_pkg::GADDR_W'($urandom_range(0, 4095)),
						bfr_pkg::BYTE_W'($urandom_range(0, 255)));
			end else if (r < 92) begin
				lim = width_reg / bfr_pkg::GLYPH_WIDTH;
				if (lim > 512)
					lim = 512;
				if (lim == 0)
					lim = 1;
				case ($urandom_range(0, 3))
					0:       x = bfr_pkg::COORD_W'($urandom_range(0, 4095));
					1:       x = bfr_pkg::COORD_W'($urandom_range(4032, 4095));
					default: x = bfr_pkg::COORD_W'(bfr_pkg::GLYPH_WIDTH
						* $urandom_range(0, lim - 1));
				endcase
				case ($urandom_range(0, 3))
					0:       y = bfr_pkg::COORD_W'($urandom_range(0, 4095));
					1:       y = bfr_pkg::COORD_W'($urandom_range(4064, 4095));
					default: y = bfr_pkg::COORD_W'($urandom_range(0, 255));
				endcase
				place_cursor(x, y);
			end else begin
				it = random_item(KIND_NONE);
				queue_item(it);
			end
		end
	endfunction

	// ------------------------------------------------------------------------
	// Configuration and phase control
	// ------------------------------------------------------------------------
	// Hold valid high across back-to-back writes; the caller drops it
	task automatic write_reg(input bfr_pkg::cfg_reg_t idx,
		input logic [bfr_pkg::CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		case (idx)
			bfr_pkg::REG_DRAW_COLOUR:  colour_reg = val;
			bfr_pkg::REG_LINE_PITCH:   pitch_reg  = val[bfr_pkg::PITCH_W-1:0];
			bfr_pkg::REG_SCREEN_WIDTH: width_reg  = val[bfr_pkg::SWIDTH_W-1:0];
			bfr_pkg::REG_GLYPH_STRIDE: stride_reg = val[bfr_pkg::STRIDE_W-1:0];
			default: ;
		endcase
	endtask

	// Write all four registers; bits above each register's width carry noise
	task automatic configure(input logic [bfr_pkg::COLOUR_W-1:0] colour,
		input logic [bfr_pkg::PITCH_W-1:0] pitch,
		input logic [bfr_pkg::SWIDTH_W-1:0] width,
		input logic [bfr_pkg::STRIDE_W-1:0] stride);
		logic [bfr_pkg::CFG_DATA_W-1:0] val;
		write_reg(bfr_pkg::REG_DRAW_COLOUR, colour);
		val = $urandom;
		val[bfr_pkg::PITCH_W-1:0] = pitch;
		write_reg(bfr_pkg::REG_LINE_PITCH, val);
		val = $urandom;
		val[bfr_pkg::SWIDTH_W-1:0] = width;
		write_reg(bfr_pkg::REG_SCREEN_WIDTH, val);
		val = $urandom;
		val[bfr_pkg::STRIDE_W-1:0] = stride;
		write_reg(bfr_pkg::REG_GLYPH_STRIDE, val);
		cfg_ch.valid <= 1'b0;
	endtask

	// Hold off until every queued item is taken and every row has come back,
	// then give a load or cursor item still in flight time to finish
	task automatic settle();
		do
			@(posedge clk);
		while (items_accepted != items_queued || expected_rows.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		logic [bfr_pkg::BYTE_W-1:0] bits;

		// Known values on the configuration inputs before the first edge
		cfg_ch.valid = 1'b0;
		cfg_ch.index = bfr_pkg::REG_DRAW_COLOUR;
		cfg_ch.data  = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset register values. Glyph 0 carries the
		// leftmost pixel alone, the rightmost alone, a full row and an empty row.
		for (int row = 0; row < ROWS; row++) begin
			case (row)
				0:       bits = 8'h80;
				1:       bits = 8'h01;
				2:       bits = 8'hFF;
				3:       bits = 8'h00;
				default: bits = bfr_pkg::BYTE_W'($urandom_range(0, 255));
			endcase
			load_byte(bfr_pkg::GADDR_W'(row), bits);
		end
		draw_char(8'd0);              // cursor straight out of reset
		place_cursor(12'd1008, 12'd0);
		draw_char(8'd0);              // leaves room for one more glyph, no wrap
		draw_char(8'd0);              // ends exactly on the right edge; next glyph would not fit: wrap
		place_cursor(12'd1016, 12'd4088);
		draw_char(8'd0);              // wrap with the line count saturating
		queue_item(random_item(KIND_NONE));
		draw_char(8'd0);              // stray item must leave the cursor alone
		random_burst(30);
		settle();

		// Top of each register's working range, with a pause mid-phase
		configure(32'hFFFF_FFFF, 13'd4096, 13'd4096, 5'd16);
		random_burst(15);
		settle();
		random_burst(15);
		settle();

		// Bottom of the working range: a wrap after every glyph
		configure(32'h0000_0000, 13'd1, 13'd8, 5'd1);
		random_burst(30);
		settle();

		// Zero pitch, width and stride: every code reads glyph 0 on one line
		configure($urandom, 13'd0, 13'd0, 5'd0);
		draw_char(8'hFF);
		draw_char(8'd0);
		random_burst(25);
		settle();

		// Widest fields: glyph addresses wrap the store, X overflows 12 bits,
		// offsets overflow 25 bits
		configure($urandom, 13'd8191, 13'd8191, 5'd31);
		place_cursor(12'd4095, 12'd4095);
		draw_char(8'hFF);
		random_burst(30);
		settle();

		// Ordinary console geometry
		configure($urandom, 13'd640, 13'd640, 5'd8);
		random_burst(35);
		settle();

		if (failures == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Hang guard, far beyond the slowest legal run
	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
